// ----- src/bcvm_pkg.sv -----
// ----------------------------------------------------------------------------
// bcvm_pkg
// Shared constants for the battery cell voltage monitor.
// ----------------------------------------------------------------------------
package bcvm_pkg;
  localparam int unsigned DtMaxUs = 50000;
  localparam int unsigned NominalCellMv = 3800;
  localparam int unsigned PresentMv = 5000;
  localparam int unsigned MinCellMv = 3000;
  localparam int unsigned MaxCellMv = 4400;
  localparam int unsigned UahDivisor = 3600000;

  typedef enum logic [2:0] {
    CfgLowThr  = 3'd0,
    CfgCritThr = 3'd1,
    CfgEmerThr = 3'd2,
    CfgHyst    = 3'd3,
    CfgLowDly  = 3'd4,
    CfgCritDly = 3'd5,
    CfgEmerDly = 3'd6,
    CfgDetDly  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DetIdle   = 2'd0,
    DetActive = 2'd1,
    DetDone   = 2'd2,
    DetFail   = 2'd3
  } det_phase_e;

  typedef enum logic [2:0] {
    LvlUnknown = 3'd0,
    LvlNormal  = 3'd1,
    LvlLow     = 3'd2,
    LvlCrit    = 3'd3,
    LvlEmer    = 3'd4
  } level_e;
endpackage

// ----- src/bcvm_serdiv.sv -----
// ----------------------------------------------------------------------------
// bcvm_serdiv
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcvm_serdiv #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 22
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    trial = {rem_q, quot_q[NumW-1]};
    diff = trial - {1'b0, den_q};
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DenW]) begin
        rem_d = diff[DenW-1:0];
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else begin
      quot_q <= quot_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o = rem_q;
endmodule

// ----- src/battery_cell_voltage_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_cell_voltage_monitor
// Pack monitor: cell count detection, per-cell voltage, undervoltage levels
// and a coulomb counter.
// ----------------------------------------------------------------------------
// One sample in, one result word out. After acceptance the sample is
// registered, then a shift-add multiplier forms current times dt (2 bits
// per step) and launches the divider. A serial divider run, one bit at a
// time, converts the charge to uAh. A second run gives the per-cell
// voltage, and then the output register is loaded. The result word sits
// in the output register. The next sample is taken once the result has
// been loaded there. The last state waits only while the previous word is
// still stalled.
module battery_cell_voltage_monitor #(
  parameter int unsigned MAX_CELLS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pack_voltage_mv_i,
  input  logic signed [18:0] pack_current_ma_i,
  input  logic        is_armed_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_voltage_mv_o,
  output logic [2:0]  battery_level_o,
  output logic [1:0]  detect_status_o,
  output logic [2:0]  cells_found_o,
  output logic [31:0] consumed_uah_o,
  output logic        arm_allowed_o
);
  import bcvm_pkg::*;

  localparam int unsigned NW = 48;
  localparam int unsigned DW = 22;

  typedef enum logic [2:0] {
    StIdle, StMul, StDivQ, StDivV, StOut
  } state_e;

  state_e state_q;
  logic [12:0] low_thr_q, crit_thr_q, emer_thr_q;
  logic [9:0]  hyst_q;
  logic [23:0] low_dly_q, crit_dly_q, emer_dly_q, det_dly_q;
  logic [31:0] last_q, wait_q, low_t_q, crit_t_q, emer_t_q, charge_q;
  logic        seen_q;
  det_phase_e  phase_q;
  logic [3:0]  cells_q;
  logic [21:0] rem_q;
  logic [15:0] v_q;
  logic        cur_pos_q;
  logic [15:0] dt_q;
  logic [47:0] acc_q;
  logic [15:0] mpl_q;
  logic [33:0] mcand_q;
  logic [3:0]  mcnt_q;
  logic        div_start, div_busy;
  logic [NW-1:0] div_num, div_quot;
  logic [DW-1:0] div_den, div_rem;
  logic        div_wait_q;
  logic        out_load;

  bcvm_serdiv #(.NumW(NW), .DenW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot), .rem_o(div_rem)
  );

  // timestamp and dt
  logic [31:0] dt_raw;
  logic [15:0] dt_in;
  assign dt_raw = now_us_i - last_q;
  assign dt_in = (seen_q && dt_raw != '0 && dt_raw <= 32'(DtMaxUs)) ? dt_raw[15:0] : '0;

  // detection, done at acceptance
  logic [31:0] wsum, wait_n;
  logic [16:0] vr;
  logic [3:0]  n_est;
  logic [17:0] vlim_lo, vlim_hi;
  logic        n_ok;
  det_phase_e  phase_n;
  logic [3:0]  cells_n;
  logic        accept;
  always_comb begin
    wsum = wait_q + 32'(dt_in);
    vr = {1'b0, pack_voltage_mv_i} + 17'(NominalCellMv / 2);
    n_est = '0;
    for (int k = 1; k <= 18; k++) begin
      if (vr >= 17'(k * NominalCellMv)) n_est = 4'(k > 15 ? 15 : k);
    end
    vlim_lo = 18'(n_est) * 18'(MinCellMv);
    vlim_hi = 18'(n_est) * 18'(MaxCellMv);
    n_ok = pack_voltage_mv_i >= 16'(PresentMv) && n_est >= 4'd1
           && n_est <= 4'(MAX_CELLS)
           && {2'b0, pack_voltage_mv_i} >= vlim_lo
           && {2'b0, pack_voltage_mv_i} <= vlim_hi;
    wait_n = wait_q;
    phase_n = phase_q;
    cells_n = cells_q;
    if (phase_q != DetDone && !is_armed_i) begin
      phase_n = DetActive;
      wait_n = (wsum < wait_q) ? '1 : wsum;
      if (wait_n >= {8'd0, det_dly_q}) begin
        if (n_ok) begin
          cells_n = n_est;
          phase_n = DetDone;
        end else begin
          phase_n = DetFail;
        end
      end
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_load = (state_q == StOut) && (!out_valid_o || !out_stall_i);

  // timers, evaluated in StOut
  function automatic logic [31:0] run_t(input logic [31:0] t, input logic [15:0] v,
      input logic [3:0] n, input logic [12:0] thr, input logic [9:0] hy,
      input logic [15:0] dt);
    logic [19:0] lo, hi;
    logic [31:0] s;
    lo = 20'(n) * 20'(thr);
    hi = 20'(n) * (20'(thr) + 20'(hy));
    s = t + 32'(dt);
    if ({4'd0, v} < lo) return (s < t) ? '1 : s;
    if ({4'd0, v} > hi) return '0;
    return t;
  endfunction

  logic [31:0] low_tn, crit_tn, emer_tn;
  level_e      lvl;
  always_comb begin
    emer_tn = run_t(emer_t_q, v_q, cells_q, emer_thr_q, hyst_q, dt_q);
    crit_tn = run_t(crit_t_q, v_q, cells_q, crit_thr_q, hyst_q, dt_q);
    low_tn  = run_t(low_t_q, v_q, cells_q, low_thr_q, hyst_q, dt_q);
    if (emer_tn >= {8'd0, emer_dly_q}) lvl = LvlEmer;
    else if (crit_tn >= {8'd0, crit_dly_q}) lvl = LvlCrit;
    else if (low_tn >= {8'd0, low_dly_q}) lvl = LvlLow;
    else lvl = LvlNormal;
  end

  always_comb begin
    div_start = 1'b0;
    div_num = acc_q;
    div_den = DW'(UahDivisor);
    if (state_q == StMul && mcnt_q == '0) div_start = 1'b1;
    if (state_q == StDivQ && !div_busy && div_wait_q) begin
      div_start = 1'b1;
      div_num = {32'd0, v_q};
      div_den = DW'(cells_q);
    end
  end

  logic [33:0] psum;
  logic [32:0] csum;
  assign psum = 34'(mpl_q[1:0]) * mcand_q;
  assign csum = {1'b0, charge_q} + {1'b0, div_quot[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      low_thr_q <= 13'd3600; crit_thr_q <= 13'd3500; emer_thr_q <= 13'd3400;
      hyst_q <= 10'd50;
      low_dly_q <= 24'd200000; crit_dly_q <= 24'd150000;
      emer_dly_q <= 24'd100000; det_dly_q <= 24'd100000;
      last_q <= '0; seen_q <= 1'b0; wait_q <= '0; phase_q <= DetIdle;
      cells_q <= '0; low_t_q <= '0; crit_t_q <= '0; emer_t_q <= '0;
      charge_q <= '0; rem_q <= '0; mcnt_q <= '0; div_wait_q <= 1'b0;
      v_q <= '0; cur_pos_q <= 1'b0; dt_q <= '0; acc_q <= '0;
      mpl_q <= '0; mcand_q <= '0;
      cell_voltage_mv_o <= '0; battery_level_o <= LvlUnknown;
      detect_status_o <= DetIdle; cells_found_o <= '0;
      consumed_uah_o <= '0; arm_allowed_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgLowThr:  low_thr_q <= cfg_data_i[12:0];
          CfgCritThr: crit_thr_q <= cfg_data_i[12:0];
          CfgEmerThr: emer_thr_q <= cfg_data_i[12:0];
          CfgHyst:    hyst_q <= cfg_data_i[9:0];
          CfgLowDly:  low_dly_q <= cfg_data_i;
          CfgCritDly: crit_dly_q <= cfg_data_i;
          CfgEmerDly: emer_dly_q <= cfg_data_i;
          CfgDetDly:  det_dly_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            last_q <= now_us_i; seen_q <= 1'b1;
            wait_q <= wait_n; phase_q <= phase_n; cells_q <= cells_n;
            v_q <= pack_voltage_mv_i;
            cur_pos_q <= !pack_current_ma_i[18] && pack_current_ma_i != '0;
            dt_q <= dt_in;
            mpl_q <= dt_in;
            mcand_q <= {16'd0, pack_current_ma_i[17:0]};
            acc_q <= {26'd0, rem_q};
            mcnt_q <= 4'd8;
            state_q <= StMul;
          end
        end
        StMul: begin
          if (mcnt_q != '0) begin
            acc_q <= acc_q + {14'd0, psum};
            mpl_q <= {2'b0, mpl_q[15:2]};
            mcand_q <= {mcand_q[31:0], 2'b0};
            mcnt_q <= mcnt_q - 1'b1;
          end else begin
            div_wait_q <= 1'b1;
            state_q <= StDivQ;
          end
        end
        StDivQ: begin
          if (!div_busy && div_wait_q) begin
            div_wait_q <= 1'b0;
            if (cells_q != '0 && cur_pos_q) begin
              rem_q <= div_rem;
              charge_q <= (div_quot[47:32] != '0 || csum[32]) ? '1 : csum[31:0];
            end
            state_q <= StDivV;
          end
        end
        StDivV: begin
          if (!div_busy && !div_start) state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            cells_found_o <= cells_q[2:0];
            detect_status_o <= phase_q;
            consumed_uah_o <= charge_q;
            if (cells_q != '0) begin
              cell_voltage_mv_o <= div_quot[15:0];
              emer_t_q <= emer_tn; crit_t_q <= crit_tn; low_t_q <= low_tn;
              battery_level_o <= lvl;
              arm_allowed_o <= (phase_q == DetDone)
                               && (lvl == LvlNormal || lvl == LvlLow);
            end else begin
              cell_voltage_mv_o <= '0;
              battery_level_o <= LvlUnknown;
              arm_allowed_o <= 1'b0;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StMul)
    else $error("sample not taken into the multiplier");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cells_found_o == '0) |-> battery_level_o == LvlUnknown)
    else $error("level without a cell count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arm_allowed_o |-> detect_status_o == DetDone)
    else $error("arm permit before detection");
endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery cell voltage monitor. A behavioral
// predictor tracks timestamps, detection, level timers and the charge
// counter; every output word is compared as a whole against it.
// ----------------------------------------------------------------------------
module tb;
  import bcvm_pkg::*;

  localparam int unsigned NumCells = 6;
  localparam int unsigned LimitCycles = 2000000;

  typedef struct packed {
    logic [15:0] cell_mv;
    level_e      level;
    det_phase_e  phase;
    logic [2:0]  cells;
    logic [31:0] uah;
    logic        arm_ok;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] pack_voltage_mv_i = '0;
  logic signed [18:0] pack_current_ma_i = '0;
  logic        is_armed_i = 1'b0;
  logic [31:0] now_us_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] cell_voltage_mv_o;
  logic [2:0]  battery_level_o;
  logic [1:0]  detect_status_o;
  logic [2:0]  cells_found_o;
  logic [31:0] consumed_uah_o;
  logic        arm_allowed_o;

  battery_cell_voltage_monitor #(.MAX_CELLS(NumCells)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [12:0] thr_low, thr_crit, thr_emer;
  logic [9:0]  hyst;
  logic [23:0] dly_low, dly_crit, dly_emer, dly_det;
  logic [31:0] last_stamp, det_wait, t_low, t_crit, t_emer, uah;
  logic        stamp_seen;
  det_phase_e  phase;
  logic [2:0]  cell_cnt;
  logic [63:0] remainder;

  status_t     expected_q[$];
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned out_wait = 0;
  logic [31:0] stamp_now = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] step_timer(logic [31:0] t, logic [31:0] v, logic [31:0] n,
                                             logic [31:0] thr, logic [31:0] dt);
    if (v < n * thr) return sat_add(t, dt);
    if (v > n * (thr + hyst)) return 0;
    return t;
  endfunction

  function automatic logic [2:0] count_cells(logic [31:0] v);
    logic [31:0] n;
    if (v < PresentMv) return '0;
    n = (v + NominalCellMv / 2) / NominalCellMv;
    if (n < 1 || n > NumCells) return '0;
    if (v < MinCellMv * n || v > MaxCellMv * n) return '0;
    return n[2:0];
  endfunction

  task automatic predict_sample(logic [15:0] v, logic signed [18:0] cur, logic armed,
                                logic [31:0] now);
    logic [31:0] dt;
    logic [63:0] acc, q;
    logic [2:0]  n;
    status_t     r;
    dt = 0;
    r = '0;
    if (stamp_seen) begin
      dt = now - last_stamp;
      if (dt < 1 || dt > DtMaxUs) dt = 0;
    end
    stamp_seen = 1'b1;
    last_stamp = now;
    if (phase != DetDone && !armed) begin
      phase = DetActive;
      det_wait = sat_add(det_wait, dt);
      if (det_wait >= dly_det) begin
        n = count_cells(v);
        if (n == 0) phase = DetFail;
        else begin
          cell_cnt = n;
          phase = DetDone;
        end
      end
    end
    r.level = LvlUnknown;
    if (cell_cnt != 0) begin
      r.cell_mv = v / cell_cnt;
      if (cur > 0) begin
        acc = remainder + 64'(cur) * dt;
        q = acc / UahDivisor;
        remainder = acc % UahDivisor;
        uah = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sat_add(uah, q[31:0]);
      end
      t_emer = step_timer(t_emer, v, cell_cnt, thr_emer, dt);
      t_crit = step_timer(t_crit, v, cell_cnt, thr_crit, dt);
      t_low = step_timer(t_low, v, cell_cnt, thr_low, dt);
      if (t_emer >= dly_emer) r.level = LvlEmer;
      else if (t_crit >= dly_crit) r.level = LvlCrit;
      else if (t_low >= dly_low) r.level = LvlLow;
      else r.level = LvlNormal;
    end
    r.phase = phase;
    r.cells = cell_cnt;
    r.uah = uah;
    r.arm_ok = phase == DetDone && (r.level == LvlNormal || r.level == LvlLow);
    expected_q.push_back(r);
  endtask

  task automatic send_sample(logic [15:0] v, logic signed [18:0] cur, logic armed,
                             logic [31:0] now);
    int unsigned gap;
    gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pack_voltage_mv_i <= v;
    pack_current_ma_i <= cur;
    is_armed_i <= armed;
    now_us_i <= now;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(v, cur, armed, now);
  endtask

  task automatic send_step(logic [15:0] v, logic signed [18:0] cur, logic armed,
                           logic [31:0] dt);
    stamp_now = stamp_now + dt;
    send_sample(v, cur, armed, stamp_now);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgLowThr:  thr_low = val[12:0];
      CfgCritThr: thr_crit = val[12:0];
      CfgEmerThr: thr_emer = val[12:0];
      CfgHyst:    hyst = val[9:0];
      CfgLowDly:  dly_low = val;
      CfgCritDly: dly_crit = val;
      CfgEmerDly: dly_emer = val;
      default:    dly_det = val;
    endcase
  endtask

  task automatic set_thresholds(logic [12:0] lo, logic [12:0] cr, logic [12:0] em,
                                logic [9:0] hy, logic [23:0] dl, logic [23:0] dc,
                                logic [23:0] de, logic [23:0] dd);
    drain_results();
    write_reg(CfgLowThr, 24'(lo));
    write_reg(CfgCritThr, 24'(cr));
    write_reg(CfgEmerThr, 24'(em));
    write_reg(CfgHyst, 24'(hy));
    write_reg(CfgLowDly, dl);
    write_reg(CfgCritDly, dc);
    write_reg(CfgEmerDly, de);
    write_reg(CfgDetDly, dd);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_sample(16'd0, -19'sd262144, 1'b1, 32'hFFFF_FFF0);
    stamp_now = 32'hFFFF_FFF0;
    send_step(16'd11400, 19'sd262143, 1'b1, 32'd10);
    send_step(16'd4000, 19'sd1000, 1'b0, 32'd50000);
    send_step(16'd65535, 19'sd1000, 1'b0, 32'd50000);
    send_step(16'd26500, 19'sd0, 1'b0, 32'd50001);
    send_step(16'd26500, 19'sd0, 1'b0, 32'd1);
    send_step(16'd11400, 19'sd262143, 1'b0, 32'd1);
    send_step(16'd11400, 19'sd262143, 1'b1, 32'd50000);
    send_step(16'd10400, -19'sd5, 1'b0, 32'd40000);
    send_step(16'd10200, 19'sd50000, 1'b0, 32'd50000);
    send_step(16'd9000, 19'sd262143, 1'b0, 32'd50000);
    send_step(16'd9000, 19'sd262143, 1'b0, 32'd50000);
    send_step(16'd9000, 19'sd262143, 1'b0, 32'd50000);
    send_step(16'd12600, 19'sd1, 1'b0, 32'd0);
    send_step(16'd0, 19'sd3, 1'b0, 32'd50000);
    send_step(16'd65535, 19'sd3, 1'b1, 32'd50000);
  endtask

  task automatic test_random(int count, int span);
    int unsigned sel;
    logic [15:0] v;
    logic [31:0] dt;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) v = 16'($urandom_range(3000, 4500) * span);
      else v = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (sel < 7) dt = $urandom_range(1, 50000);
      else if (sel < 8) dt = 0;
      else if (sel < 9) dt = $urandom_range(50001, 60000);
      else dt = $urandom;
      send_step(v, 19'($signed($urandom_range(0, 524287))) >>> $urandom_range(0, 12),
                $urandom_range(0, 9) == 0, dt);
      if (i == count / 2) drain_results();
    end
  endtask

  task automatic test_detection_retry();
    set_thresholds(13'd5000, 13'd5000, 13'd5000, 10'd1000, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 24'd0);
    for (int i = 0; i < 60; i++)
      send_step(16'($urandom_range(0, 30000)), 19'sd100, 1'($urandom_range(0, 1)),
                32'd1000);
  endtask

  always @(posedge clk_i) begin
    status_t got, exp_r;
    int unsigned w;
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout at %0t", $realtime);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        w = $urandom_range(0, 17);
        out_wait <= w;
        out_stall_i <= (w != 0);
      end else if (out_valid_o && out_wait != 0) begin
        out_wait <= out_wait - 1;
        out_stall_i <= (out_wait > 1);
      end
    end
    if (out_valid_o && !out_stall_i) begin
      got = {cell_voltage_mv_o, level_e'(battery_level_o), det_phase_e'(detect_status_o),
             cells_found_o, consumed_uah_o, arm_allowed_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got != exp_r) begin
          errors++;
          $display("%0t: mismatch exp cell=%0d lvl=%0d det=%0d n=%0d uah=%0d arm=%0d",
                   $realtime, exp_r.cell_mv, exp_r.level, exp_r.phase, exp_r.cells,
                   exp_r.uah, exp_r.arm_ok);
          $display("%0t:          act cell=%0d lvl=%0d det=%0d n=%0d uah=%0d arm=%0d",
                   $realtime, got.cell_mv, got.level, got.phase, got.cells, got.uah,
                   got.arm_ok);
        end
      end
    end
  end

  task automatic reset_predictor();
    thr_low = 3600; thr_crit = 3500; thr_emer = 3400; hyst = 50;
    dly_low = 200000; dly_crit = 150000; dly_emer = 100000; dly_det = 100000;
    last_stamp = 0; stamp_seen = 0; det_wait = 0; phase = DetIdle; cell_cnt = 0;
    t_low = 0; t_crit = 0; t_emer = 0; uah = 0; remainder = 0;
  endtask

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600, 3);
    set_thresholds(13'd0, 13'd0, 13'd0, 10'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF);
    test_random(300, 3);
    set_thresholds(13'd3700, 13'd3600, 13'd3500, 10'd20, 24'd30000, 24'd60000,
                   24'd90000, 24'd0);
    test_random(500, 3);
    set_thresholds(13'd8191, 13'd4000, 13'd3300, 10'd1023, 24'd500, 24'hFFFFFF,
                   24'd1000, 24'd5000);
    test_random(400, 3);
    test_detection_retry();
    drain_results();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/bcvm_pkg.sv
src/bcvm_serdiv.sv
src/battery_cell_voltage_monitor.sv
test/tb.sv
